// ----- src/png_cw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_cw_pkg
// Types, codes and signature table for the PNG/MNG/JNG chunk walker.
// ----------------------------------------------------------------------------
package png_cw_pkg;

   localparam int OUT_SIZE_W     = 40;
   localparam int SIG_LEN        = 8;
   localparam int CHUNK_OVERHEAD = 12;
   localparam int CRC_LEN        = 4;

   localparam logic [1:0] FMT_PNG = 2'd0;
   localparam logic [1:0] FMT_MNG = 2'd1;
   localparam logic [1:0] FMT_JNG = 2'd2;

   localparam logic [1:0] REASON_END      = 2'd0;
   localparam logic [1:0] REASON_BAD_TYPE = 2'd1;
   localparam logic [1:0] REASON_SIG      = 2'd2;
   localparam logic [1:0] REASON_OVERFLOW = 2'd3;

   localparam logic [31:0] TAG_IEND = 32'h49454E44;
   localparam logic [31:0] TAG_MEND = 32'h4D454E44;

   localparam logic [2:0] CAND_ALL = 3'b111;

   typedef struct packed {
      logic                  fire;
      logic [1:0]            format;
      logic [1:0]            reason;
      logic [OUT_SIZE_W-1:0] total_size;
   } png_cw_result_type;

   function automatic logic [7:0] sig_byte(input logic [1:0] fmt, input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: begin
            case (fmt)
               FMT_PNG: b = 8'h89;
               FMT_MNG: b = 8'h8a;
               default: b = 8'h8b;
            endcase
         end
         3'd1: begin
            case (fmt)
               FMT_PNG: b = 8'h50;
               FMT_MNG: b = 8'h4d;
               default: b = 8'h4a;
            endcase
         end
         3'd2:    b = 8'h4e;
         3'd3:    b = 8'h47;
         3'd4:    b = 8'h0d;
         3'd5:    b = 8'h0a;
         3'd6:    b = 8'h1a;
         default: b = 8'h0a;
      endcase
      return b;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
   endfunction

endpackage

// ----- src/png_cw_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_cw_if
// Valid/ready channels for input bytes and walk results.
// ----------------------------------------------------------------------------
interface png_cw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface png_cw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  format;
   logic [1:0]  reason;
   logic [39:0] total_size;

   modport source (output valid, output format, output reason, output total_size,
                   input ready);
   modport sink   (input valid, input format, input reason, input total_size,
                   output ready);
endinterface

// ----- src/png_cw_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_cw_core
// Parse state and per-byte step logic: signature match, header capture,
// data/CRC skip, end/bad-type/overflow detection.
// ----------------------------------------------------------------------------
module png_cw_core
   import png_cw_pkg::*;
#(
   parameter int SIZE_BITS = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        data_byte,
   input  logic              start_req,
   output png_cw_result_type result
);

   typedef enum logic [1:0] {
      PH_SIG,
      PH_HDR,
      PH_SKIP
   } phase_type;

   localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

   phase_type            phase_ff, phase_in;
   logic [2:0]           count_ff, count_in;
   logic [2:0]           cand_ff, cand_in;
   logic                 fin_ff, fin_in;
   logic [31:0]          len_ff, len_in;
   logic [23:0]          type_ff, type_in;
   logic [32:0]          skip_ff, skip_in;
   logic [SIZE_BITS-1:0] run_ff, run_in;

   phase_type            ph;
   logic [2:0]           cnt;
   logic [2:0]           cand;
   logic                 fin;
   logic [31:0]          len;
   logic [23:0]          typ;
   logic [32:0]          skip;
   logic [SIZE_BITS-1:0] run;

   logic [2:0]           cand_m;
   logic [1:0]           fmt;
   logic [31:0]          full_type;
   logic [32:0]          add;
   logic [SIZE_BITS:0]   sum;
   logic [32:0]          skip_dec;
   logic                 letters_ok;
   logic                 fire;
   logic [1:0]           rsn;
   logic [1:0]           rfmt;
   logic [SIZE_BITS-1:0] size_sel;
   logic [SIZE_BITS+OUT_SIZE_W-1:0] size_ext;

   always_comb begin
      ph   = start_req ? PH_SIG   : phase_ff;
      cnt  = start_req ? 3'd0     : count_ff;
      cand = start_req ? CAND_ALL : cand_ff;
      fin  = start_req ? 1'b0     : fin_ff;
      len  = start_req ? 32'd0    : len_ff;
      typ  = start_req ? 24'd0    : type_ff;
      skip = start_req ? 33'd0    : skip_ff;
      run  = start_req ? '0       : run_ff;

      for (int k = 0; k < 3; k++)
         cand_m[k] = cand[k] && (sig_byte(2'(k), cnt) == data_byte);

      fmt = cand[2] ? FMT_JNG : (cand[1] ? FMT_MNG : FMT_PNG);
      full_type = {typ, data_byte};
      add = {1'b0, len} + 33'(CHUNK_OVERHEAD);
      sum = {1'b0, run} + (SIZE_BITS+1)'(add);
      skip_dec = skip - {32'd0, (skip != 33'd0)};
      letters_ok = is_letter(full_type[31:24]) && is_letter(full_type[23:16]) &&
                   is_letter(full_type[15:8]) && is_letter(full_type[7:0]);

      phase_in = ph;
      count_in = cnt;
      cand_in  = cand;
      fin_in   = fin;
      len_in   = len;
      type_in  = typ;
      skip_in  = skip;
      run_in   = run;
      fire     = 1'b0;
      rsn      = REASON_END;
      rfmt     = FMT_PNG;
      size_sel = '0;

      if (!fin) begin
         unique case (ph)
            PH_SIG: begin
               cand_in = cand_m;
               if (cand_m == 3'b000) begin
                  fire     = 1'b1;
                  rsn      = REASON_SIG;
                  size_sel = SIZE_BITS'({1'b0, cnt} + 4'd1);
                  fin_in   = 1'b1;
               end else if (cnt == 3'(SIG_LEN - 1)) begin
                  phase_in = PH_HDR;
                  count_in = 3'd0;
                  run_in   = SIZE_BITS'(SIG_LEN);
               end else begin
                  count_in = cnt + 3'd1;
               end
            end
            PH_HDR: begin
               if (!cnt[2]) len_in  = {len[23:0], data_byte};
               else         type_in = {typ[15:0], data_byte};
               if (cnt != 3'd7) begin
                  count_in = cnt + 3'd1;
               end else begin
                  rfmt = fmt;
                  if (sum[SIZE_BITS]) begin
                     fire     = 1'b1;
                     rsn      = REASON_OVERFLOW;
                     size_sel = SIZE_MAX;
                     fin_in   = 1'b1;
                  end else if (full_type == ((fmt == FMT_MNG) ? TAG_MEND : TAG_IEND)) begin
                     fire     = 1'b1;
                     rsn      = REASON_END;
                     size_sel = sum[SIZE_BITS-1:0];
                     fin_in   = 1'b1;
                  end else if ((fmt != FMT_MNG) && !letters_ok) begin
                     fire     = 1'b1;
                     rsn      = REASON_BAD_TYPE;
                     size_sel = run;
                     fin_in   = 1'b1;
                  end else begin
                     run_in   = sum[SIZE_BITS-1:0];
                     skip_in  = {1'b0, len} + 33'(CRC_LEN);
                     count_in = 3'd0;
                     len_in   = 32'd0;
                     type_in  = 24'd0;
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 33'd0) begin
                  phase_in = PH_HDR;
                  count_in = 3'd0;
               end
            end
            default: begin
               phase_in = PH_SIG;
            end
         endcase
      end

      size_ext          = {{OUT_SIZE_W{1'b0}}, size_sel};
      result.fire       = fire;
      result.format     = rfmt;
      result.reason     = rsn;
      result.total_size = size_ext[OUT_SIZE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG;
         count_ff <= 3'd0;
         cand_ff  <= CAND_ALL;
         fin_ff   <= 1'b1;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         cand_ff  <= cand_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         len_ff  <= len_in;
         type_ff <= type_in;
         skip_ff <= skip_in;
         run_ff  <= run_in;
      end
   end

endmodule

// ----- src/png_chunk_walker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_walker_top
// PNG/MNG/JNG chunk walker: input register, parse core, result register.
// ----------------------------------------------------------------------------
// A byte's result is offered on rsp from the result register.
// Throughput: one byte per cycle while the parse step is not held (see below).
// The result register frees the input side while a result waits; only a
// byte that yields a second result stalls until the first one transfers.
// Reset: synchronous; the block idles until a byte with start_req set.
// ----------------------------------------------------------------------------
module png_chunk_walker_top
   import png_cw_pkg::*;
#(
   parameter int SIZE_BITS = 40
) (
   input logic          clock,
   input logic          reset,
   png_cw_req_if.sink   req_if,
   png_cw_rsp_if.source rsp_if
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_start_ff;
   logic              out_valid_ff, out_valid_in;
   png_cw_result_type out_ff;
   png_cw_result_type res;
   logic              advance;
   logic              req_xfer;

   assign advance       = in_valid_ff && (!res.fire || !out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_xfer      = req_if.valid && req_if.ready;

   png_cw_core #(
      .SIZE_BITS (SIZE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .start_req (in_start_ff),
      .result    (res)
   );

   always_comb begin
      in_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance && res.fire) out_valid_in = 1'b1;
      else if (rsp_if.ready)   out_valid_in = 1'b0;
      else                     out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff  <= req_if.data_byte;
         in_start_ff <= req_if.start_req;
      end
      if (advance && res.fire) begin
         out_ff <= res;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.format     = out_ff.format;
   assign rsp_if.reason     = out_ff.reason;
   assign rsp_if.total_size = out_ff.total_size;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_if.ready)
      else $error("input register empty but not ready");

   a_format_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.format == FMT_PNG || out_ff.format == FMT_MNG ||
                        out_ff.format == FMT_JNG))
      else $error("unused format code on result");

   a_sig_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.reason == REASON_SIG) |->
         (out_ff.format == FMT_PNG && out_ff.total_size >= 40'd1 &&
          out_ff.total_size <= 40'(SIG_LEN)))
      else $error("signature mismatch result out of range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("valid state survived reset");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for png_chunk_walker_top.
// A short table of directed bytes is followed by random PNG, MNG and JNG
// files. These are mostly well-formed chunk streams, and some have a bad
// signature, a bad chunk type, a huge length or a cut-off end. Each byte
// transfer runs an in-bench walker model. Each result transfer is checked
// field by field against the oldest pending prediction. Both channels get
// random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb;
   import png_cw_pkg::*;

   localparam int TOTAL_ITEMS  = 1250;
   localparam int CALM_ITEMS   = 150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_ROWS     = 22;
   localparam logic [63:0] SIZE_LIMIT = (64'd1 << OUT_SIZE_W) - 64'd1;

   typedef struct packed {
      logic [1:0]            format;
      logic [1:0]            reason;
      logic [OUT_SIZE_W-1:0] total_size;
   } walk_result_type;

   typedef enum logic [1:0] {WALK_SIG, WALK_HDR, WALK_SKIP} walk_stage_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} row_check_type;

   typedef struct packed {
      logic [7:0]      data;
      logic            start;
      row_check_type   chk;
      walk_result_type res;
   } stim_row_type;

   localparam walk_result_type NO_RESULT = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   png_cw_req_if req_if ();
   png_cw_rsp_if rsp_if ();

   png_chunk_walker_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #5 clock = ~clock;

   // walker model state
   walk_stage_type walk_stage;
   logic [3:0]     hdr_pos;
   logic [2:0]     fmt_cand;
   logic [31:0]    len_acc;
   logic [31:0]    tag_acc;
   logic [32:0]    skip_left;
   logic [63:0]    size_acc;
   logic           walk_idle;

   walk_result_type pending_results [$];
   stim_row_type    dir_rows [NUM_ROWS];
   int              live_items;
   int              err_count;
   int              quiet_cycles;
   logic            gaps_on;

   function automatic void clear_walk();
      walk_stage = WALK_SIG;
      hdr_pos    = 4'd0;
      fmt_cand   = CAND_ALL;
      len_acc    = '0;
      tag_acc    = '0;
      skip_left  = '0;
      size_acc   = '0;
      walk_idle  = 1'b1;
   endfunction

   function automatic logic [63:0] sig_word(input logic [1:0] fmt);
      case (fmt)
         FMT_PNG: return 64'h89504E470D0A1A0A;
         FMT_MNG: return 64'h8A4D4E470D0A1A0A;
         default: return 64'h8B4A4E470D0A1A0A;
      endcase
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
   endfunction

   function automatic void walk_byte(input logic [7:0] b, input logic st,
                                     output logic fire, output walk_result_type res);
      logic [63:0] word;
      logic [63:0] add_len;
      logic [63:0] chunk_base;
      logic [1:0]  fmt;
      logic [31:0] end_tag;
      logic        letters;
      fire = 1'b0;
      res  = NO_RESULT;
      if (st) begin
         clear_walk();
         walk_idle = 1'b0;
      end
      if (!walk_idle) begin
         case (walk_stage)
            WALK_SIG: begin
               for (int k = 0; k < 3; k++) begin
                  word = sig_word(2'(k));
                  if (word[63 - 8*hdr_pos -: 8] != b) fmt_cand[k] = 1'b0;
               end
               if (fmt_cand == 3'b000) begin
                  fire = 1'b1;
                  res  = '{FMT_PNG, REASON_SIG, 40'(hdr_pos) + 40'd1};
               end else if (hdr_pos == 4'd7) begin
                  walk_stage = WALK_HDR;
                  hdr_pos    = 4'd0;
                  size_acc   = 64'(SIG_LEN);
               end else begin
                  hdr_pos++;
               end
            end
            WALK_HDR: begin
               if (hdr_pos < 4) len_acc = {len_acc[23:0], b};
               else tag_acc = {tag_acc[23:0], b};
               if (hdr_pos < 7) begin
                  hdr_pos++;
               end else begin
                  fmt        = fmt_cand[2] ? FMT_JNG : (fmt_cand[1] ? FMT_MNG : FMT_PNG);
                  add_len    = 64'(len_acc) + 64'(CHUNK_OVERHEAD);
                  chunk_base = size_acc;
                  end_tag    = (fmt == FMT_MNG) ? TAG_MEND : TAG_IEND;
                  letters    = is_alpha(tag_acc[31:24]) && is_alpha(tag_acc[23:16]) &&
                               is_alpha(tag_acc[15:8]) && is_alpha(tag_acc[7:0]);
                  if (add_len > SIZE_LIMIT - size_acc) begin
                     fire = 1'b1;
                     res  = '{fmt, REASON_OVERFLOW, SIZE_LIMIT[OUT_SIZE_W-1:0]};
                  end else begin
                     size_acc = size_acc + add_len;
                     if (tag_acc == end_tag) begin
                        fire = 1'b1;
                        res  = '{fmt, REASON_END, size_acc[OUT_SIZE_W-1:0]};
                     end else if (fmt != FMT_MNG && !letters) begin
                        fire = 1'b1;
                        res  = '{fmt, REASON_BAD_TYPE, chunk_base[OUT_SIZE_W-1:0]};
                     end else begin
                        skip_left  = 33'(len_acc) + 33'(CRC_LEN);
                        hdr_pos    = 4'd0;
                        len_acc    = '0;
                        tag_acc    = '0;
                        walk_stage = WALK_SKIP;
                     end
                  end
               end
            end
            default: begin
               if (skip_left != 0) skip_left--;
               if (skip_left == 0) begin
                  walk_stage = WALK_HDR;
                  hdr_pos    = 4'd0;
               end
            end
         endcase
         if (fire) walk_idle = 1'b1;
      end
   endfunction

   task automatic send_item(input logic [7:0] b, input logic st, input row_check_type chk,
                            input walk_result_type fixed);
      logic            fire;
      walk_result_type res;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.start_req <= st;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (st || !walk_idle) live_items++;
      walk_byte(b, st, fire, res);
      if (chk == CHK_FIXED) pending_results.push_back(fixed);
      else if (chk == CHK_MODEL && fire) pending_results.push_back(res);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_chunk(input logic [31:0] len, input logic [31:0] tag, input int body);
      for (int i = 0; i < 4; i++) send_item(len[31 - 8*i -: 8], 1'b0, CHK_MODEL, NO_RESULT);
      for (int i = 0; i < 4; i++) send_item(tag[31 - 8*i -: 8], 1'b0, CHK_MODEL, NO_RESULT);
      repeat (body) send_item(8'($urandom_range(0, 255)), 1'b0, CHK_MODEL, NO_RESULT);
   endtask

   task automatic send_file();
      logic [1:0]  fmt;
      logic [63:0] sig;
      logic [7:0]  b;
      logic [31:0] len;
      logic [31:0] tag;
      logic [31:0] end_tag;
      logic [31:0] alt_tag;
      int          mode;
      int          cut;
      int          n_sig;
      int          n_chunks;
      int          bad_chunk;
      fmt   = 2'($urandom_range(0, 2));
      sig   = sig_word(fmt);
      mode  = $urandom_range(0, 99);
      cut   = (mode < 12) ? $urandom_range(0, 7) : 8;
      n_sig = (mode >= 12 && mode < 18) ? $urandom_range(1, 7) : 8;
      for (int i = 0; i < n_sig; i++) begin
         b = sig[63 - 8*i -: 8];
         if (i == cut) b = b ^ 8'($urandom_range(1, 255));
         send_item(b, i == 0, CHK_MODEL, NO_RESULT);
         if (i == cut) break;
      end
      if (mode < 18) begin
         // trailing bytes after a mismatch are ignored; after a cut they land in the parse
         repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0, CHK_MODEL,
                                                 NO_RESULT);
         return;
      end
      end_tag   = (fmt == FMT_MNG) ? TAG_MEND : TAG_IEND;
      alt_tag   = (fmt == FMT_MNG) ? TAG_IEND : TAG_MEND;
      n_chunks  = $urandom_range(0, 3);
      bad_chunk = (mode < 30) ? $urandom_range(0, n_chunks) : -1;
      for (int c = 0; c <= n_chunks; c++) begin
         len = 32'($urandom_range(0, 6));
         if ($urandom_range(0, 15) == 0) len = $urandom;
         if (c == n_chunks) tag = end_tag;
         else tag = {rand_letter(), rand_letter(), rand_letter(), rand_letter()};
         if (c != n_chunks && $urandom_range(0, 9) == 0) tag = alt_tag;
         if (c != n_chunks && fmt == FMT_MNG && $urandom_range(0, 3) == 0) tag = $urandom;
         if (c == bad_chunk) begin
            case ($urandom_range(0, 4))
               0:       b = 8'h40;
               1:       b = 8'h5B;
               2:       b = 8'h60;
               3:       b = 8'h7B;
               default: b = 8'($urandom_range(0, 255));
            endcase
            tag[8*$urandom_range(0, 3) +: 8] = b;
         end
         if (len > 32'd64) begin
            send_chunk(len, tag, $urandom_range(0, 6));
            return;
         end
         if (c == n_chunks) send_chunk(len, tag, $urandom_range(0, 1) ? int'(len) + 4 : 0);
         else send_chunk(len, tag, int'(len) + 4);
      end
   endtask

   // receiver stall bursts
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) stall_left--;
         else if (gaps_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
         rsp_if.ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      walk_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            err_count++;
            $display("%0t: unexpected result: expected none, actual fmt=%0d reason=%0d size=%0d",
                     $time, rsp_if.format, rsp_if.reason, rsp_if.total_size);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.format !== want.format) begin
               err_count++;
               $display("%0t: format mismatch: expected %0d, actual %0d",
                        $time, want.format, rsp_if.format);
            end
            if (rsp_if.reason !== want.reason) begin
               err_count++;
               $display("%0t: reason mismatch: expected %0d, actual %0d",
                        $time, want.reason, rsp_if.reason);
            end
            if (rsp_if.total_size !== want.total_size) begin
               err_count++;
               $display("%0t: total_size mismatch: expected %0d, actual %0d",
                        $time, want.total_size, rsp_if.total_size);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired with %0d results pending", $time,
                  pending_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.start_req = 1'b0;
      live_items       = 0;
      err_count        = 0;
      quiet_cycles     = 0;
      gaps_on          = 1'b1;
      clear_walk();
      dir_rows = '{
         '{8'h89, 1'b0, CHK_NONE,  NO_RESULT},                      // idle after reset
         '{8'h00, 1'b1, CHK_FIXED, '{FMT_PNG, REASON_SIG, 40'd1}},
         '{8'h89, 1'b1, CHK_MODEL, NO_RESULT},
         '{8'h50, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h4E, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h47, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h0D, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h0A, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h1A, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h0A, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'hFF, 1'b0, CHK_MODEL, NO_RESULT},                      // max length
         '{8'hFF, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'hFF, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'hFF, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h61, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h5A, 1'b0, CHK_MODEL, NO_RESULT},
         '{8'h40, 1'b0, CHK_MODEL, NO_RESULT},                      // just below 'A'
         '{8'h7A, 1'b0, CHK_FIXED, '{FMT_PNG, REASON_BAD_TYPE, 40'd8}},
         '{8'hFF, 1'b1, CHK_FIXED, '{FMT_PNG, REASON_SIG, 40'd1}},
         '{8'h8A, 1'b1, CHK_MODEL, NO_RESULT},
         '{8'h58, 1'b0, CHK_FIXED, '{FMT_PNG, REASON_SIG, 40'd2}},
         '{8'h8B, 1'b0, CHK_NONE,  NO_RESULT}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_item(dir_rows[i].data, dir_rows[i].start, dir_rows[i].chk, dir_rows[i].res);
      drain_results();
      while (live_items < TOTAL_ITEMS) begin
         gaps_on = (live_items < TOTAL_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 24) == 0) drain_results();
         send_file();
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
